// ===== rtl/tpc_pkg.sv =====
// Shared types and constants for the tire packet checker.
// Used by tpc_tire_table and tire_packet_check_and_link_stats.
package tpc_pkg;

	localparam int MAX_TIRES = 16;
	localparam int TIRE_AW   = (MAX_TIRES > 1) ? $clog2(MAX_TIRES) : 1;

	// result status codes
	localparam logic [1:0] ST_GOOD    = 2'd0;
	localparam logic [1:0] ST_BAD_CHK = 2'd1;
	localparam logic [1:0] ST_BAD_ID  = 2'd2;
	localparam logic [1:0] ST_CLEARED = 2'd3;

	// configuration register indexes
	localparam logic REG_TIRE_COUNT = 1'b0;
	localparam logic REG_LAT_LIMIT  = 1'b1;

	localparam logic [4:0]         TIRE_COUNT_RST = 5'd12;
	localparam logic [15:0]        LAT_LIMIT_RST  = 16'd30000;
	localparam logic signed [11:0] RSSI_PEAK_RST  = -12'sd2000;

	// per-tire record held in the table memory
	typedef struct packed {
		logic [31:0] arrival;
		logic [31:0] gap;
		logic [31:0] count;
	} tire_entry_t;

	typedef struct packed {
		logic               en;
		logic [TIRE_AW-1:0] addr;
	} tab_rd_t;

	typedef struct packed {
		logic               en;
		logic               clr;
		logic [TIRE_AW-1:0] addr;
		tire_entry_t        data;
	} tab_wr_t;

endpackage

// ===== rtl/tire_packet_check_and_link_stats.sv =====
// Tire packet checker with link statistics: top level.
// Depends on tpc_pkg and tpc_tire_table.
//
// Takes one item per clock unless stage 1 is held by a stalled result. An item
// is checked (checksum, tire id) in the cycle it is accepted while its tire
// record is read from the table memory; when stage 1 advances it updates
// counters, RSSI extremes, latency and the tire record, and loads the result
// register. Back-to-back items on the same tire are served by forwarding the
// pending write-back, so there are no bubbles. Reset and the clear command
// take effect at once through per-entry valid bits; there is no clearing pass.
// Configuration writes are taken in any cycle.
module tire_packet_check_and_link_stats (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               mode,
	input  logic [31:0]        sender_time_ms,
	input  logic [15:0]        status_word,
	input  logic [15:0]        battery_mv,
	input  logic [15:0]        pressure_deci_kpa,
	input  logic [7:0]         tire_number,
	input  logic signed [7:0]  temperature_c,
	input  logic signed [7:0]  sensor_rssi,
	input  logic [7:0]         packet_check,
	input  logic signed [11:0] link_rssi,
	input  logic [31:0]        arrival_ms,
	// output channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         result_status,
	output logic [15:0]        latency_ms,
	output logic               latency_fresh,
	output logic [31:0]        tire_interval_ms,
	output logic [31:0]        tire_packets,
	output logic [31:0]        total_packets,
	output logic [31:0]        good_packets,
	output logic [31:0]        checksum_errors,
	output logic [31:0]        id_errors,
	output logic signed [11:0] rssi_lowest,
	output logic signed [11:0] rssi_highest
);
	import tpc_pkg::*;

	logic [4:0]  tire_count_q;
	logic [15:0] lat_limit_q;

	// stage 1
	logic                 s1_vld_q;
	logic [1:0]           st_s1;
	logic signed [11:0]   rssi_s1;
	logic [31:0]          ts_s1;
	logic [31:0]          now_s1;
	logic [TIRE_AW-1:0]   addr_s1;

	// statistics
	logic [31:0]        total_q, good_q, bad_chk_q, bad_id_q;
	logic signed [11:0] floor_q, peak_q;
	logic [15:0]        last_lat_q;

	// result register
	logic               out_vld_q;
	logic [1:0]         res_st_q;
	logic [15:0]        res_lat_q;
	logic               res_fresh_q;
	logic [31:0]        res_gap_q, res_cnt_q;
	logic [31:0]        res_total_q, res_good_q, res_chk_q, res_id_q;
	logic signed [11:0] res_floor_q, res_peak_q;

	logic        in_acc, s1_adv, s1_fire, s1_good, s1_clr;
	logic [7:0]  cs;
	logic        id_ok;
	logic [1:0]  st_in;
	tab_rd_t     tab_rd;
	tab_wr_t     tab_wr;
	tire_entry_t ent;
	logic [31:0] gap_new, cnt_new, lat_diff;
	logic        lat_ok;

	logic [31:0]        total_n, good_n, chk_n, id_n;
	logic signed [11:0] floor_n, peak_n;
	logic [15:0]        lat_n;

	// ---------------- handshake ----------------
	assign s1_adv   = !out_vld_q || !out_stall;
	assign in_stall = s1_vld_q && !s1_adv;
	assign in_acc   = in_valid && !in_stall;
	assign s1_fire  = s1_vld_q && s1_adv;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tire_count_q <= TIRE_COUNT_RST;
			lat_limit_q  <= LAT_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TIRE_COUNT: tire_count_q <= cfg_data[4:0];
				REG_LAT_LIMIT:  lat_limit_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- check stage ----------------
	assign cs = sender_time_ms[7:0] ^ sender_time_ms[15:8]
		^ sender_time_ms[23:16] ^ sender_time_ms[31:24]
		^ status_word[7:0] ^ status_word[15:8]
		^ battery_mv[7:0] ^ battery_mv[15:8]
		^ pressure_deci_kpa[7:0] ^ pressure_deci_kpa[15:8]
		^ tire_number ^ $unsigned(temperature_c) ^ $unsigned(sensor_rssi);

	// usable count is min(tire_count, MAX_TIRES)
	assign id_ok = ({1'b0, tire_number} < {4'b0, tire_count_q})
		&& ({1'b0, tire_number} < 9'(MAX_TIRES));

	always_comb begin
		if (mode) begin
			st_in = ST_CLEARED;
		end else if (cs != packet_check) begin
			st_in = ST_BAD_CHK;
		end else if (!id_ok) begin
			st_in = ST_BAD_ID;
		end else begin
			st_in = ST_GOOD;
		end
	end

	assign tab_rd.en   = in_acc;
	assign tab_rd.addr = tire_number[TIRE_AW-1:0];

	// an empty stage takes an item even while the result register is held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
		end else if (s1_adv || !s1_vld_q) begin
			s1_vld_q <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			st_s1   <= st_in;
			rssi_s1 <= link_rssi;
			ts_s1   <= sender_time_ms;
			now_s1  <= arrival_ms;
			addr_s1 <= tire_number[TIRE_AW-1:0];
		end
	end

	tpc_tire_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd      (tab_rd),
		.wr      (tab_wr),
		.rd_data (ent)
	);

	// ---------------- update stage ----------------
	assign s1_good  = (st_s1 == ST_GOOD);
	assign s1_clr   = (st_s1 == ST_CLEARED);
	// stored arrival of zero means no earlier packet
	assign gap_new  = (ent.arrival != 32'd0) ? (now_s1 - ent.arrival) : ent.gap;
	assign cnt_new  = ent.count + 32'd1;
	assign lat_diff = now_s1 - ts_s1;
	assign lat_ok   = s1_good && (ts_s1 < now_s1) && (lat_diff < {16'b0, lat_limit_q});

	assign tab_wr.en           = s1_fire && s1_good;
	assign tab_wr.clr          = s1_fire && s1_clr;
	assign tab_wr.addr         = addr_s1;
	assign tab_wr.data.arrival = now_s1;
	assign tab_wr.data.gap     = gap_new;
	assign tab_wr.data.count   = cnt_new;

	always_comb begin
		total_n = total_q;
		good_n  = good_q;
		chk_n   = bad_chk_q;
		id_n    = bad_id_q;
		floor_n = floor_q;
		peak_n  = peak_q;
		lat_n   = last_lat_q;
		case (st_s1)
			ST_CLEARED: begin
				total_n = '0;
				good_n  = '0;
				chk_n   = '0;
				id_n    = '0;
				floor_n = '0;
				peak_n  = RSSI_PEAK_RST;
				lat_n   = '0;
			end
			ST_BAD_CHK: begin
				total_n = total_q + 32'd1;
				chk_n   = bad_chk_q + 32'd1;
			end
			ST_BAD_ID: begin
				total_n = total_q + 32'd1;
				id_n    = bad_id_q + 32'd1;
			end
			default: begin
				total_n = total_q + 32'd1;
				good_n  = good_q + 32'd1;
				if (rssi_s1 < floor_q) begin
					floor_n = rssi_s1;
				end
				if (rssi_s1 > peak_q) begin
					peak_n = rssi_s1;
				end
				if (lat_ok) begin
					lat_n = lat_diff[15:0];
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= '0;
			good_q     <= '0;
			bad_chk_q  <= '0;
			bad_id_q   <= '0;
			floor_q    <= '0;
			peak_q     <= RSSI_PEAK_RST;
			last_lat_q <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			if (s1_fire) begin
				total_q    <= total_n;
				good_q     <= good_n;
				bad_chk_q  <= chk_n;
				bad_id_q   <= id_n;
				floor_q    <= floor_n;
				peak_q     <= peak_n;
				last_lat_q <= lat_n;
			end
			if (s1_adv) begin
				out_vld_q <= s1_vld_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			res_st_q    <= st_s1;
			res_lat_q   <= lat_n;
			res_fresh_q <= lat_ok;
			res_gap_q   <= s1_good ? gap_new : 32'd0;
			res_cnt_q   <= s1_good ? cnt_new : 32'd0;
			res_total_q <= total_n;
			res_good_q  <= good_n;
			res_chk_q   <= chk_n;
			res_id_q    <= id_n;
			res_floor_q <= floor_n;
			res_peak_q  <= peak_n;
		end
	end

	assign out_valid        = out_vld_q;
	assign result_status    = res_st_q;
	assign latency_ms       = res_lat_q;
	assign latency_fresh    = res_fresh_q;
	assign tire_interval_ms = res_gap_q;
	assign tire_packets     = res_cnt_q;
	assign total_packets    = res_total_q;
	assign good_packets     = res_good_q;
	assign checksum_errors  = res_chk_q;
	assign id_errors        = res_id_q;
	assign rssi_lowest      = res_floor_q;
	assign rssi_highest     = res_peak_q;

`ifndef SYNTHESIS
	a_count_sum: assert property (@(posedge clk) disable iff (!arst_n)
		total_q == good_q + bad_chk_q + bad_id_q)
		else $error("packet counters out of balance");

	a_bad_no_tire: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_status != ST_GOOD)
		|-> (tire_packets == 32'd0) && (tire_interval_ms == 32'd0) && !latency_fresh)
		else $error("tire fields set on a non-good result");

	a_rssi_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_status == ST_GOOD) |-> (rssi_lowest <= rssi_highest))
		else $error("rssi extremes inverted after a good item");

	a_fresh_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && latency_fresh |-> (latency_ms < lat_limit_q))
		else $error("fresh latency not below limit");

	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		tab_wr.en |-> !tab_wr.clr && s1_adv)
		else $error("table write without stage advance");
`endif

endmodule

// ===== rtl/tpc_tire_table.sv =====
// Per-tire record memory: synchronous read, valid bits for reset/clear, and
// forwarding of a write that lands on the entry being read.
// Depends on tpc_pkg.
module tpc_tire_table (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tpc_pkg::tab_rd_t     rd,
	input  tpc_pkg::tab_wr_t     wr,
	output tpc_pkg::tire_entry_t rd_data
);
	import tpc_pkg::*;

	tire_entry_t          mem [MAX_TIRES];
	logic [MAX_TIRES-1:0] valid_q;
	tire_entry_t          rd_q;
	tire_entry_t          fwd_q;
	logic                 hit_q;
	logic                 rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rd_q  <= mem[rd.addr];
			fwd_q <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			hit_q    <= 1'b0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.clr) begin
				valid_q <= '0;
			end else if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			if (rd.en) begin
				// a write on the same edge is not yet in the array
				hit_q    <= wr.en && (wr.addr == rd.addr);
				rd_vld_q <= valid_q[rd.addr] && !wr.clr;
			end
		end
	end

	assign rd_data = hit_q ? fwd_q : (rd_vld_q ? rd_q : '0);

endmodule
